### src/tsd_pkg.sv
// shared types, constants and conversion functions for the tga stream decoder
package tsd_pkg;

    localparam int PaletteDepth = 256;
    localparam int PalAw = $clog2(PaletteDepth);
    localparam int QueueDepth = 4;
    localparam int QueueAw = $clog2(QueueDepth);

    typedef logic [QueueAw-1:0] qptr_t;
    typedef logic [QueueAw:0] qcnt_t;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_BAD_PAL = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_IDSKIP  = 6'b000010,
        PH_PALETTE = 6'b000100,
        PH_PKTHEAD = 6'b001000,
        PH_PIXEL   = 6'b010000,
        PH_IDLE    = 6'b100000
    } phase_t;

    // one classified word passed from front to back
    typedef struct packed {
        logic        is_err;
        logic [1:0]  status;
        logic        pal_lookup;
        logic [31:0] value;
        logic [15:0] pal_off;
        logic [15:0] pal_len;
        logic [31:0] color;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  len;
        logic        image_end;
    } job_t;

    function automatic logic [31:0] to_argb(input logic [31:0] v, input logic [7:0] bits);
        logic [31:0] r;
        case (bits)
            8'd16: r = (v[15] ? 32'hFF000000 : 32'h0) + ({16'h0, v[15:0] & 16'h001F} << 3)
                     + ({16'h0, v[15:0] & 16'h03E0} << 6) + ({16'h0, v[15:0] & 16'h7C00} << 9);
            8'd24: r = 32'hFF000000 + (v & 32'h00FFFFFF);
            8'd32: r = v;
            default: r = 32'hFF000000;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] bytes_for(input logic [7:0] bits);
        logic [5:0] n;
        n = 6'((9'(bits) + 9'd7) >> 3);
        if (n < 6'd1) n = 6'd1;
        if (n > 6'd4) n = 6'd4;
        return 3'(n);
    endfunction

endpackage

### src/tsd_ram.sv
// generic single-port-write ram with registered read
module tsd_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/tsd_front.sv
// header parser, palette loader and packet classifier
module tsd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic                   push,
    output logic                   full,
    input  logic                   q_full,
    input  logic                   pal_busy,
    output logic                   q_push,
    output tsd_pkg::job_t          q_job,
    output logic                   pal_we,
    output logic [tsd_pkg::PalAw-1:0] pal_waddr,
    output logic [31:0]            pal_wdata
);
    tsd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  hcnt_reg, hcnt_next;
    logic [7:0]  idlen_reg, idlen_next;
    logic        mapp_reg, mapp_next;
    logic [7:0]  itype_reg, itype_next;
    logic [15:0] moff_reg, moff_next;
    logic [15:0] mlen_reg, mlen_next;
    logic [7:0]  mbits_reg, mbits_next;
    logic [15:0] w_reg, w_next;
    logic [15:0] h_reg, h_next;
    logic [7:0]  pbits_reg, pbits_next;
    logic        top_reg, top_next;
    logic [1:0]  biv_reg, biv_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] x_reg, x_next;
    logic [15:0] row_reg, row_next;
    logic [7:0]  pleft_reg, pleft_next;
    logic        prun_reg, prun_next;

    logic        take;
    logic [31:0] gval;
    logic        gdone;
    logic [7:0]  gbits;
    logic        rle;
    logic [16:0] len;
    logic [15:0] rem;
    logic [15:0] xs;

    // palette writes wait until no queued lookup can still read the old palette
    assign full = q_full || (pal_busy && phase_reg == tsd_pkg::PH_PALETTE);
    assign take = push && !full;
    assign rle = itype_reg[3];
    assign gbits = (phase_reg == tsd_pkg::PH_PALETTE) ? mbits_reg : pbits_reg;
    assign gval = acc_reg | ({24'h0, data_byte} << (6'd8 * {4'h0, biv_reg}));
    assign gdone = ({1'b0, biv_reg} + 3'd1) >= tsd_pkg::bytes_for(gbits);

    always_comb
    begin
        phase_next = phase_reg; hcnt_next = hcnt_reg; idlen_next = idlen_reg;
        mapp_next = mapp_reg; itype_next = itype_reg; moff_next = moff_reg;
        mlen_next = mlen_reg; mbits_next = mbits_reg; w_next = w_reg; h_next = h_reg;
        pbits_next = pbits_reg; top_next = top_reg; biv_next = biv_reg; acc_next = acc_reg;
        cnt_next = cnt_reg; x_next = x_reg; row_next = row_reg; pleft_next = pleft_reg;
        prun_next = prun_reg;
        q_push = 1'b0;
        q_job = '0;
        pal_we = 1'b0;
        pal_waddr = cnt_reg[tsd_pkg::PalAw-1:0];
        pal_wdata = tsd_pkg::to_argb(gval, mbits_reg);
        len = 17'd1;
        rem = w_reg - x_reg;
        xs = '0;
        if (take)
        begin
            case (phase_reg)
                tsd_pkg::PH_HEADER:
                begin
                    case (hcnt_reg)
                        5'd0: idlen_next = data_byte;
                        5'd1: mapp_next = (data_byte == 8'd1);
                        5'd2: itype_next = data_byte;
                        5'd3: moff_next = {8'h0, data_byte};
                        5'd4: moff_next = {data_byte, moff_reg[7:0]};
                        5'd5: mlen_next = {8'h0, data_byte};
                        5'd6: mlen_next = {data_byte, mlen_reg[7:0]};
                        5'd7: mbits_next = data_byte;
                        5'd12: w_next = {8'h0, data_byte};
                        5'd13: w_next = {data_byte, w_reg[7:0]};
                        5'd14: h_next = {8'h0, data_byte};
                        5'd15: h_next = {data_byte, h_reg[7:0]};
                        5'd16: pbits_next = data_byte;
                        5'd17: top_next = data_byte[5];
                        default: ;
                    endcase
                    hcnt_next = hcnt_reg + 5'd1;
                    if (hcnt_reg == 5'd17)
                    begin
                        hcnt_next = '0;
                        biv_next = '0; acc_next = '0; cnt_next = '0;
                        x_next = '0; row_next = '0; pleft_next = '0; prun_next = 1'b0;
                        if (mapp_reg && (mlen_reg == 16'd0
                            || 17'(mlen_reg) > 17'(tsd_pkg::PaletteDepth)))
                        begin
                            q_push = 1'b1;
                            q_job.is_err = 1'b1;
                            q_job.status = tsd_pkg::ST_BAD_PAL;
                            phase_next = tsd_pkg::PH_IDLE;
                        end
                        else if (idlen_reg != 8'd0)
                        begin
                            cnt_next = {8'h0, idlen_reg};
                            phase_next = tsd_pkg::PH_IDSKIP;
                        end
                        else if (mapp_reg)
                            phase_next = tsd_pkg::PH_PALETTE;
                        else if (w_next == 16'd0 || h_reg == 16'd0)
                            phase_next = tsd_pkg::PH_IDLE;
                        else
                            phase_next = rle ? tsd_pkg::PH_PKTHEAD : tsd_pkg::PH_PIXEL;
                    end
                end
                tsd_pkg::PH_IDSKIP:
                begin
                    cnt_next = cnt_reg - 16'd1;
                    if (cnt_reg <= 16'd1)
                    begin
                        cnt_next = '0;
                        if (mapp_reg)
                            phase_next = tsd_pkg::PH_PALETTE;
                        else if (w_reg == 16'd0 || h_reg == 16'd0)
                            phase_next = tsd_pkg::PH_IDLE;
                        else
                            phase_next = rle ? tsd_pkg::PH_PKTHEAD : tsd_pkg::PH_PIXEL;
                    end
                end
                tsd_pkg::PH_PALETTE:
                begin
                    biv_next = biv_reg + 2'd1;
                    acc_next = gval;
                    if (gdone)
                    begin
                        biv_next = '0; acc_next = '0;
                        pal_we = 17'(cnt_reg) < 17'(tsd_pkg::PaletteDepth);
                        cnt_next = cnt_reg + 16'd1;
                        if (cnt_next >= mlen_reg)
                        begin
                            if (w_reg == 16'd0 || h_reg == 16'd0)
                                phase_next = tsd_pkg::PH_IDLE;
                            else
                                phase_next = rle ? tsd_pkg::PH_PKTHEAD : tsd_pkg::PH_PIXEL;
                        end
                    end
                end
                tsd_pkg::PH_PKTHEAD:
                begin
                    prun_next = data_byte[7];
                    pleft_next = {1'b0, data_byte[6:0]} + 8'd1;
                    biv_next = '0; acc_next = '0;
                    phase_next = tsd_pkg::PH_PIXEL;
                end
                tsd_pkg::PH_PIXEL:
                begin
                    biv_next = biv_reg + 2'd1;
                    acc_next = gval;
                    if (gdone)
                    begin
                        biv_next = '0; acc_next = '0;
                        if (rle && prun_reg)
                        begin
                            len = {9'h0, pleft_reg};
                            if (len > 17'(rem)) len = 17'(rem);
                            pleft_next = '0;
                        end
                        else if (rle && pleft_reg != 8'd0)
                            pleft_next = pleft_reg - 8'd1;
                        q_push = 1'b1;
                        q_job.status = tsd_pkg::ST_RUN;
                        q_job.pal_lookup = (itype_reg[2:0] == 3'd1) && mapp_reg;
                        q_job.value = gval;
                        q_job.pal_off = moff_reg;
                        q_job.pal_len = mlen_reg;
                        q_job.color = tsd_pkg::to_argb(gval, pbits_reg);
                        q_job.x = x_reg;
                        q_job.y = top_reg ? row_reg : (h_reg - 16'd1 - row_reg);
                        q_job.len = len[7:0];
                        xs = x_reg + len[15:0];
                        x_next = xs;
                        if (xs >= w_reg)
                        begin
                            x_next = '0;
                            row_next = row_reg + 16'd1;
                            pleft_next = '0;
                        end
                        if (row_next >= h_reg)
                        begin
                            q_job.image_end = 1'b1;
                            phase_next = tsd_pkg::PH_IDLE;
                        end
                        else if (rle && pleft_next == 8'd0)
                            phase_next = tsd_pkg::PH_PKTHEAD;
                    end
                end
                default: ;
            endcase
            if (last_byte)
            begin
                if (phase_next != tsd_pkg::PH_IDLE)
                begin
                    q_push = 1'b1;
                    q_job = '0;
                    q_job.is_err = 1'b1;
                    q_job.status = tsd_pkg::ST_TRUNC;
                end
                phase_next = tsd_pkg::PH_HEADER; hcnt_next = '0;
                biv_next = '0; acc_next = '0; cnt_next = '0;
                x_next = '0; row_next = '0; pleft_next = '0; prun_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tsd_pkg::PH_HEADER; hcnt_reg <= '0; idlen_reg <= '0;
            mapp_reg <= 1'b0; itype_reg <= '0; moff_reg <= '0; mlen_reg <= '0;
            mbits_reg <= '0; w_reg <= '0; h_reg <= '0; pbits_reg <= '0; top_reg <= 1'b0;
            biv_reg <= '0; acc_reg <= '0; cnt_reg <= '0; x_reg <= '0; row_reg <= '0;
            pleft_reg <= '0; prun_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; hcnt_reg <= hcnt_next; idlen_reg <= idlen_next;
            mapp_reg <= mapp_next; itype_reg <= itype_next; moff_reg <= moff_next;
            mlen_reg <= mlen_next; mbits_reg <= mbits_next; w_reg <= w_next;
            h_reg <= h_next; pbits_reg <= pbits_next; top_reg <= top_next;
            biv_reg <= biv_next; acc_reg <= acc_next; cnt_reg <= cnt_next;
            x_reg <= x_next; row_reg <= row_next; pleft_reg <= pleft_next;
            prun_reg <= prun_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hcnt: assert property (@(posedge clk) disable iff (!rst_n) hcnt_reg <= 5'd17)
        else $error("header count out of range");
    a_biv: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != tsd_pkg::PH_PALETTE && phase_reg != tsd_pkg::PH_PIXEL |-> biv_reg == 2'd0)
        else $error("partial value outside gather phases");
    a_push: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> take)
        else $error("queue push without accepted word");
`endif
endmodule

### src/tsd_back.sv
// queue, palette index modulo, palette read and output register
module tsd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_push,
    input  tsd_pkg::job_t          q_job,
    output logic                   q_full,
    output logic                   pal_busy,
    output logic [tsd_pkg::PalAw-1:0] pal_raddr,
    input  logic [31:0]            pal_rdata,
    input  logic                   pop,
    output logic                   empty,
    output logic [31:0]            color,
    output logic [15:0]            col_x,
    output logic [15:0]            row_y,
    output logic [7:0]             run_length,
    output logic [1:0]             status,
    output logic                   image_end
);
    tsd_pkg::job_t q_mem [tsd_pkg::QueueDepth];
    tsd_pkg::qptr_t wp_reg, rp_reg;
    tsd_pkg::qcnt_t qc_reg;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MOD  = 5'b00010,
        B_READ = 5'b00100,
        B_DATA = 5'b01000,
        B_OUT  = 5'b10000
    } bst_t;
    bst_t st_reg, st_next;
    tsd_pkg::job_t job_reg, job_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] div_reg, div_next;
    logic [4:0]  sh_reg, sh_next;
    logic        q_pop;
    logic [16:0] sub;
    logic [31:0] sum;

    assign q_full = qc_reg == tsd_pkg::qcnt_t'(tsd_pkg::QueueDepth);
    assign pal_busy = qc_reg != '0 || st_reg == B_MOD || st_reg == B_READ;
    assign empty = st_reg != B_OUT;
    assign color = job_reg.color;
    assign col_x = job_reg.x;
    assign row_y = job_reg.y;
    assign run_length = job_reg.len;
    assign status = job_reg.status;
    assign image_end = job_reg.image_end;
    assign pal_raddr = rem_reg[tsd_pkg::PalAw-1:0];
    // index sum wraps at 32 bits
    assign sum = q_mem[rp_reg].value + {16'h0, q_mem[rp_reg].pal_off};
    assign sub = rem_reg - div_reg;

    // restoring modulo: bring (value+offset) below length one bit a cycle
    always_comb
    begin
        st_next = st_reg; job_next = job_reg; rem_next = rem_reg; div_next = div_reg;
        sh_next = sh_reg; q_pop = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                if (qc_reg != '0)
                begin
                    q_pop = 1'b1;
                    job_next = q_mem[rp_reg];
                    if (q_mem[rp_reg].is_err)
                        st_next = B_OUT;
                    else if (q_mem[rp_reg].pal_lookup)
                    begin
                        st_next = B_MOD;
                        sh_next = 5'd31;
                        job_next.value = {sum[30:0], 1'b0};
                        rem_next = {16'h0, sum[31]};
                        div_next = {1'b0, q_mem[rp_reg].pal_len};
                    end
                    else
                        st_next = B_OUT;
                end
            end
            B_MOD:
            begin
                if (rem_reg >= div_reg) rem_next = sub;
                else rem_next = rem_reg;
                job_next.value = {job_reg.value[30:0], 1'b0};
                if (sh_reg == 5'd0)
                    st_next = B_READ;
                else
                begin
                    rem_next = {(rem_reg >= div_reg ? sub[15:0] : rem_reg[15:0]),
                                job_reg.value[31]};
                    sh_next = sh_reg - 5'd1;
                end
            end
            B_READ: st_next = B_DATA;
            B_DATA:
            begin
                job_next.color = pal_rdata;
                st_next = B_OUT;
            end
            B_OUT: if (pop) st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_push && !q_full) q_mem[wp_reg] <= q_job;
        job_reg <= job_next; rem_reg <= rem_next; div_reg <= div_next; sh_reg <= sh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; qc_reg <= '0; st_reg <= B_IDLE;
        end
        else
        begin
            st_reg <= st_next;
            if (q_push && !q_full) wp_reg <= wp_reg + tsd_pkg::qptr_t'(1);
            if (q_pop) rp_reg <= rp_reg + tsd_pkg::qptr_t'(1);
            qc_reg <= qc_reg + tsd_pkg::qcnt_t'(q_push && !q_full) - tsd_pkg::qcnt_t'(q_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        qc_reg <= tsd_pkg::qcnt_t'(tsd_pkg::QueueDepth))
        else $error("queue overflow");
    a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> qc_reg != '0)
        else $error("queue underflow");
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == B_READ |-> rem_reg < div_reg)
        else $error("palette index not reduced");
`endif
endmodule

### src/tga_stream_decoder.sv
// tga stream decoder: one file byte per word in, pixel runs out
// front takes a byte per cycle unless the 4-word queue is full or a palette load waits
// a direct-color run goes through the queue and then the output register to the result ports
// a palette run first reduces its index in the modulo state, then reads the palette ram
// the back end holds one result at a time and takes the next job only after the last is popped
// reset clears control state; the palette ram is undefined until loaded
module tga_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        push,
    output logic        full,
    output logic [31:0] color,
    output logic [15:0] col_x,
    output logic [15:0] row_y,
    output logic [7:0]  run_length,
    output logic [1:0]  status,
    output logic        image_end,
    output logic        empty,
    input  logic        pop
);
    logic q_full, q_push, pal_we, pal_busy;
    tsd_pkg::job_t q_job;
    logic [tsd_pkg::PalAw-1:0] pal_waddr, pal_raddr;
    logic [31:0] pal_wdata, pal_rdata;

    tsd_front u_front (
        .clk(clk), .rst_n(rst_n), .data_byte(data_byte), .last_byte(last_byte),
        .push(push), .full(full), .q_full(q_full), .pal_busy(pal_busy), .q_push(q_push),
        .q_job(q_job), .pal_we(pal_we), .pal_waddr(pal_waddr), .pal_wdata(pal_wdata)
    );

    tsd_ram #(.Width(32), .Depth(tsd_pkg::PaletteDepth)) u_pal (
        .clk(clk), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
        .raddr(pal_raddr), .rdata(pal_rdata)
    );

    tsd_back u_back (
        .clk(clk), .rst_n(rst_n), .q_push(q_push), .q_job(q_job), .q_full(q_full),
        .pal_busy(pal_busy), .pal_raddr(pal_raddr), .pal_rdata(pal_rdata), .pop(pop),
        .empty(empty), .color(color), .col_x(col_x), .row_y(row_y),
        .run_length(run_length), .status(status), .image_end(image_end)
    );
endmodule

### bench/tb_tga_stream_decoder.sv
// testbench for the tga stream decoder: directed and random files checked against a predictor
`timescale 1ns / 100ps

module tb_tga_stream_decoder;

    typedef struct packed {
        logic [31:0] color;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  len;
        logic [1:0]  st;
        logic        fin;
    } pixel_run_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] color;
    logic [15:0] col_x;
    logic [15:0] row_y;
    logic [7:0]  run_length;
    logic [1:0]  status;
    logic        image_end;

    tga_stream_decoder u_dut (
        .clk(clk), .rst_n(rst_n), .data_byte(data_byte), .last_byte(last_byte),
        .push(push), .full(full), .color(color), .col_x(col_x), .row_y(row_y),
        .run_length(run_length), .status(status), .image_end(image_end),
        .empty(empty), .pop(pop)
    );

    always #1 clk = ~clk;

    pixel_run_t  expected_runs[$];
    logic [7:0]  file_bytes[$];
    int          errors = 0;
    int          words_sent = 0;
    int          runs_seen = 0;
    int          files_sent = 0;
    int          bad_pal_seen = 0;
    int          trunc_seen = 0;
    int          stall_cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    // decoder shadow state
    tsd_pkg::phase_t ph = tsd_pkg::PH_HEADER;
    int unsigned hdr_cnt, id_len, map_on, img_type, map_off, map_len, map_bits;
    int unsigned img_w, img_h, pix_bits, top_org, byte_idx, accum, entry_cnt;
    int unsigned cur_x, cur_row, pkt_left, pkt_run;
    logic [31:0] palette[tsd_pkg::PaletteDepth];

    function automatic int unsigned value_bytes(int unsigned bits);
        int unsigned n;
        n = (bits + 7) >> 3;
        if (n < 1) n = 1;
        if (n > 4) n = 4;
        return n;
    endfunction

    function automatic logic [31:0] argb_of(logic [31:0] v, int unsigned bits);
        logic [31:0] a;
        if (bits == 16)
        begin
            a = v[15] ? 32'hFF000000 : 32'h0;
            return a + ((v & 32'h001F) << 3) + ((v & 32'h03E0) << 6) + ((v & 32'h7C00) << 9);
        end
        if (bits == 24) return 32'hFF000000 + (v & 32'h00FFFFFF);
        if (bits == 32) return v;
        return 32'hFF000000;
    endfunction

    function automatic bit collect(logic [7:0] b, int unsigned bits, output logic [31:0] v);
        accum = accum | (32'(b) << (8 * (byte_idx & 3)));
        byte_idx++;
        v = accum;
        if (byte_idx >= value_bytes(bits))
        begin
            accum = 0;
            byte_idx = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void start_image();
        cur_x = 0; cur_row = 0; pkt_left = 0; pkt_run = 0; byte_idx = 0; accum = 0;
        if (img_w == 0 || img_h == 0) ph = tsd_pkg::PH_IDLE;
        else ph = img_type[3] ? tsd_pkg::PH_PKTHEAD : tsd_pkg::PH_PIXEL;
    endfunction

    function automatic void leave_id();
        if (map_on != 0)
        begin
            entry_cnt = 0; byte_idx = 0; accum = 0;
            ph = tsd_pkg::PH_PALETTE;
        end
        else
        begin
            start_image();
        end
    endfunction

    function automatic void restart_file();
        ph = tsd_pkg::PH_HEADER; hdr_cnt = 0; byte_idx = 0; accum = 0; entry_cnt = 0;
        cur_x = 0; cur_row = 0; pkt_left = 0; pkt_run = 0;
    endfunction

    function automatic void reset_decoder();
        id_len = 0; map_on = 0; img_type = 0; map_off = 0; map_len = 0; map_bits = 0;
        img_w = 0; img_h = 0; pix_bits = 0; top_org = 0;
        restart_file();
    endfunction

    function automatic void predict_word(logic [7:0] b, bit last);
        pixel_run_t  r;
        bit          got;
        bit          rle;
        logic [31:0] v;
        int unsigned len, rem, idx;
        got = 1'b0;
        r = '0;
        case (ph)
            tsd_pkg::PH_HEADER:
            begin
                case (hdr_cnt)
                    0: id_len = 32'(b);
                    1: map_on = 32'(b == 8'd1);
                    2: img_type = 32'(b);
                    3: map_off = 32'(b);
                    4: map_off = map_off | (32'(b) << 8);
                    5: map_len = 32'(b);
                    6: map_len = map_len | (32'(b) << 8);
                    7: map_bits = 32'(b);
                    12: img_w = 32'(b);
                    13: img_w = img_w | (32'(b) << 8);
                    14: img_h = 32'(b);
                    15: img_h = img_h | (32'(b) << 8);
                    16: pix_bits = 32'(b);
                    17: top_org = 32'(b[5]);
                    default: ;
                endcase
                hdr_cnt++;
                if (hdr_cnt >= 18)
                begin
                    hdr_cnt = 0;
                    if (map_on != 0 && (map_len == 0 || map_len > tsd_pkg::PaletteDepth))
                    begin
                        r.st = tsd_pkg::ST_BAD_PAL;
                        got = 1'b1;
                        ph = tsd_pkg::PH_IDLE;
                    end
                    else if (id_len != 0)
                    begin
                        entry_cnt = id_len;
                        ph = tsd_pkg::PH_IDSKIP;
                    end
                    else
                    begin
                        leave_id();
                    end
                end
            end
            tsd_pkg::PH_IDSKIP:
            begin
                if (entry_cnt != 0) entry_cnt--;
                if (entry_cnt == 0) leave_id();
            end
            tsd_pkg::PH_PALETTE:
            begin
                if (collect(b, map_bits, v))
                begin
                    if (entry_cnt < tsd_pkg::PaletteDepth)
                        palette[entry_cnt] = argb_of(v, map_bits);
                    entry_cnt++;
                    if (entry_cnt >= map_len) start_image();
                end
            end
            tsd_pkg::PH_PKTHEAD:
            begin
                pkt_run = 32'(b[7]);
                pkt_left = 32'(b[6:0]) + 1;
                byte_idx = 0; accum = 0;
                ph = tsd_pkg::PH_PIXEL;
            end
            tsd_pkg::PH_PIXEL:
            begin
                if (collect(b, pix_bits, v))
                begin
                    rle = img_type[3];
                    len = 1;
                    if (rle && pkt_run != 0)
                    begin
                        rem = img_w - cur_x;
                        len = pkt_left;
                        if (len > rem) len = rem;
                        pkt_left = 0;
                    end
                    else if (rle && pkt_left != 0)
                    begin
                        pkt_left--;
                    end
                    if (img_type[2:0] == 3'd1 && map_on != 0)
                    begin
                        idx = (v + map_off) % map_len;
                        r.color = palette[idx];
                    end
                    else
                    begin
                        r.color = argb_of(v, pix_bits);
                    end
                    r.x = cur_x[15:0];
                    r.y = top_org != 0 ? cur_row[15:0] : 16'(img_h - 1 - cur_row);
                    r.len = len[7:0];
                    r.st = tsd_pkg::ST_RUN;
                    got = 1'b1;
                    cur_x += len;
                    if (cur_x >= img_w)
                    begin
                        cur_x = 0;
                        cur_row++;
                        pkt_left = 0;
                    end
                    if (cur_row >= img_h)
                    begin
                        r.fin = 1'b1;
                        ph = tsd_pkg::PH_IDLE;
                    end
                    else if (rle && pkt_left == 0)
                    begin
                        ph = tsd_pkg::PH_PKTHEAD;
                    end
                end
            end
            default: ;
        endcase
        if (last)
        begin
            if (ph != tsd_pkg::PH_IDLE)
            begin
                r = '0;
                r.st = tsd_pkg::ST_TRUNC;
                got = 1'b1;
            end
            restart_file();
        end
        if (got) expected_runs.push_back(r);
    endfunction

    // one word through the push/full handshake
    task automatic send_word(logic [7:0] b, bit last);
        while (idle_on && $urandom_range(99) < 27)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        data_byte <= b;
        last_byte <= last;
        push <= 1'b1;
        do @(posedge clk); while (full);
        predict_word(b, last);
        words_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_word(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
        files_sent++;
    endtask

    task automatic put_le(int unsigned v, int unsigned n);
        for (int i = 0; i < n; i++) file_bytes.push_back(8'(v >> (8 * i)));
    endtask

    task automatic put_header(int unsigned idl, int unsigned cmap, int unsigned typ,
                              int unsigned off, int unsigned len, int unsigned ebits,
                              int unsigned w, int unsigned h, int unsigned bpp,
                              int unsigned desc);
        put_le(idl, 1); put_le(cmap, 1); put_le(typ, 1);
        put_le(off, 2); put_le(len, 2); put_le(ebits, 1);
        put_le($urandom, 4);
        put_le(w, 2); put_le(h, 2); put_le(bpp, 1); put_le(desc, 1);
        for (int i = 0; i < idl; i++) put_le($urandom, 1);
        for (int i = 0; i < len && cmap == 1; i++) put_le($urandom, value_bytes(ebits));
    endtask

    // pixel data: raw pixels or packets, covering the image plus some slack
    task automatic put_pixels(int unsigned typ, int unsigned w, int unsigned h,
                              int unsigned bpp, int unsigned slack);
        int unsigned total;
        int unsigned cnt;
        bit          run;
        total = w * h + slack;
        while (total > 0)
        begin
            if (typ[3])
            begin
                cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
                run = $urandom_range(1);
                put_le({run, 7'(cnt - 1)}, 1);
                repeat (run ? 1 : cnt) put_le($urandom, value_bytes(bpp));
                total = (cnt >= total) ? 0 : total - cnt;
            end
            else
            begin
                put_le($urandom, value_bytes(bpp));
                total--;
            end
        end
    endtask

    task automatic random_image(int unsigned w, int unsigned h);
        int unsigned typ, cmap, len, ebits, bpp;
        int unsigned kinds[6] = '{1, 2, 3, 9, 10, 11};
        int unsigned depths[6] = '{8, 15, 16, 24, 32, 0};
        int unsigned ebs[4] = '{15, 16, 24, 32};
        typ = kinds[$urandom_range(5)];
        cmap = (typ[2:0] == 3'd1) ? 1 : ($urandom_range(3) == 0);
        len = cmap ? $urandom_range(1, 8) : 0;
        ebits = ebs[$urandom_range(3)];
        bpp = (typ[2:0] == 3'd1) ? 8 : depths[$urandom_range(5)];
        put_header($urandom_range(3), cmap, typ, $urandom_range(65535), len, ebits,
                   w, h, bpp, $urandom_range(255));
        put_pixels(typ, w, h, bpp, $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
        // drop the tail now and then so the file ends early
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4))
                if (file_bytes.size() > 1) void'(file_bytes.pop_back());
        send_file();
    endtask

    task automatic test_directed();
        // raw truecolor 2x2, bottom-up, 24 bit
        put_header(0, 0, 2, 0, 0, 0, 2, 2, 24, 0);
        put_pixels(2, 2, 2, 24, 0);
        send_file();
        // 16-bit with alpha bit both ways, top-down, id field skipped
        put_header(5, 0, 2, 0, 0, 0, 2, 1, 16, 8'h20);
        put_le(16'hFFFF, 2); put_le(16'h7FFF, 2);
        send_file();
        // full 256-entry palette with offset wrapping, 16-bit entries, rle
        put_header(0, 1, 9, 65535, 256, 16, 3, 2, 8, 8'h20);
        file_bytes.push_back(8'h82); put_le(8'hFF, 1);
        file_bytes.push_back(8'h02); put_le(0, 1); put_le(255, 1); put_le(7, 1);
        send_file();
        // 16 and 24 bit palette entries
        put_header(0, 1, 1, 3, 4, 16, 2, 1, 8, 0);
        put_pixels(1, 2, 1, 8, 0);
        send_file();
        put_header(0, 1, 1, 1, 2, 24, 1, 1, 8, 0);
        put_pixels(1, 1, 1, 8, 0);
        send_file();
        // bad palette lengths: zero and above the store
        put_header(0, 1, 1, 0, 0, 24, 2, 2, 8, 0);
        put_le(0, 3);
        send_file();
        put_header(0, 1, 1, 0, 0, 24, 2, 2, 8, 0);
        file_bytes[5] = 8'h2C; file_bytes[6] = 8'h01;
        send_file();
        // empty image, then odd depths of zero and over 32
        put_header(0, 0, 2, 0, 0, 0, 0, 3, 24, 0);
        send_file();
        put_header(0, 0, 2, 0, 0, 0, 2, 1, 0, 0);
        put_pixels(2, 2, 1, 0, 2);
        send_file();
        put_header(0, 0, 10, 0, 0, 0, 3, 1, 40, 0);
        put_pixels(10, 3, 1, 40, 0);
        send_file();
        // widest image: long run clipped by nothing, then file ends early
        put_header(0, 0, 10, 0, 0, 0, 65535, 65535, 8, 0);
        file_bytes.push_back(8'hFF); put_le(8'h5A, 1);
        file_bytes.push_back(8'h7F); repeat (3) put_le($urandom, 1);
        send_file();
        // run clipped at the row end, raw packet dropped at row end
        put_header(0, 0, 10, 0, 0, 0, 3, 2, 8, 0);
        file_bytes.push_back(8'h84); put_le(1, 1);
        file_bytes.push_back(8'h05); repeat (6) put_le($urandom, 1);
        file_bytes.push_back(8'h80); put_le(2, 1);
        send_file();
    endtask

    task automatic test_backpressure();
        push <= 1'b0;
        hold_req = 1'b1;
        wait (hold_left > 0);
        hold_req = 1'b0;
        put_header(0, 0, 2, 0, 0, 0, 8, 8, 8, 0);
        put_pixels(2, 8, 8, 8, 0);
        send_file();
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (6) random_image($urandom_range(1, 6), $urandom_range(1, 4));
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        int unsigned n;
        while (words_sent < 1550)
        begin
            if ($urandom_range(99) < 85)
            begin
                random_image($urandom_range(1, 6), $urandom_range(1, 4));
            end
            else
            begin
                n = $urandom_range(1, 30);
                repeat (n) put_le($urandom, 1);
                send_file();
            end
        end
    endtask

    // result side: pop with random stalls and one long hold
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left <= 300;
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= !idle_on || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
    begin
        pixel_run_t e;
        if (rst_n && pop && !empty)
        begin
            runs_seen++;
            if (status == tsd_pkg::ST_BAD_PAL) bad_pal_seen++;
            if (status == tsd_pkg::ST_TRUNC) trunc_seen++;
            if (expected_runs.size() == 0)
            begin
                $display("%0t: unexpected word color=%h x=%0d y=%0d len=%0d st=%0d end=%0d",
                         $time, color, col_x, row_y, run_length, status, image_end);
                errors++;
            end
            else
            begin
                e = expected_runs.pop_front();
                if (color !== e.color || col_x !== e.x || row_y !== e.y ||
                    run_length !== e.len || status !== e.st || image_end !== e.fin)
                begin
                    $display("%0t: mismatch expected color=%h x=%0d y=%0d len=%0d st=%0d end=%0d",
                             $time, e.color, e.x, e.y, e.len, e.st, e.fin);
                    $display("%0t:          actual   color=%h x=%0d y=%0d len=%0d st=%0d end=%0d",
                             $time, color, col_x, row_y, run_length, status, image_end);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000)
        begin
            $display("tb_tga_stream_decoder: FAIL");
            $finish;
        end
    end

    initial
    begin
        reset_decoder();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_no_idle();
        test_random();
        push <= 1'b0;
        last_byte <= 1'b0;
        wait (expected_runs.size() == 0);
        repeat (40) @(posedge clk);
        $display("covered %0d files, %0d words in, %0d results out", files_sent, words_sent,
                 runs_seen);
        $display("bad palette reports %0d, early file ends %0d", bad_pal_seen, trunc_seen);
        if (errors == 0)
            $display("tb_tga_stream_decoder: PASS");
        else
            $display("tb_tga_stream_decoder: FAIL");
        $finish;
    end

endmodule
